// ----- rtl/ssb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths, register indexes and the color quantizer for the
// scaled sprite blitter. Depends on nothing; ssb_front, ssb_back and the top use it.
package ssb_pkg;

  // Field widths of the input and result items.
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SDIM_W  = 9;
  localparam int unsigned FDIM_W  = 11;
  localparam int unsigned NUM_W   = POS_W + SDIM_W;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned COLOR_W = 6;
  localparam int unsigned CHAN_W  = 8;

  // Stream packing.
  localparam int unsigned IN_DATA_W    = 72;
  localparam int unsigned OUT_DATA_W   = 32;
  localparam int unsigned IN_INDEX_LSB = 0;
  localparam int unsigned IN_PIXEL_LSB = IN_INDEX_LSB + IDX_W;
  localparam int unsigned IN_COL_LSB   = IN_PIXEL_LSB + PIX_W;
  localparam int unsigned IN_ROW_LSB   = IN_COL_LSB + POS_W;

  // Source bitmap store and front-to-back queue.
  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_W     = 11;

  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LEFT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_TOP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd7;

  localparam logic [SDIM_W-1:0] RST_SOURCE_WIDTH  = 9'd1;
  localparam logic [SDIM_W-1:0] RST_SOURCE_HEIGHT = 9'd1;
  localparam logic [FDIM_W-1:0] RST_TARGET_LEFT   = 11'd0;
  localparam logic [FDIM_W-1:0] RST_TARGET_TOP    = 11'd0;
  localparam logic [FDIM_W-1:0] RST_TARGET_WIDTH  = 11'd1;
  localparam logic [FDIM_W-1:0] RST_TARGET_HEIGHT = 11'd1;
  localparam logic [FDIM_W-1:0] RST_FRAME_WIDTH   = 11'd320;
  localparam logic [FDIM_W-1:0] RST_FRAME_HEIGHT  = 11'd200;

  // Channel quantizer (c*3+127)/255, reduced to the three input thresholds
  // at which the result steps up.
  localparam int unsigned QuantMul   = 3;
  localparam int unsigned QuantBias  = 127;
  localparam int unsigned QuantDiv   = 255;
  localparam int unsigned QuantStep1 = (QuantDiv * 1 - QuantBias + QuantMul - 1) / QuantMul;
  localparam int unsigned QuantStep2 = (QuantDiv * 2 - QuantBias + QuantMul - 1) / QuantMul;
  localparam int unsigned QuantStep3 = (QuantDiv * 3 - QuantBias + QuantMul - 1) / QuantMul;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } opcode_e;

  // What the back end has to do with a queued item.
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SKIP,
    KIND_DRAW
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_DONE
  } back_state_e;

  // One classified item in the queue.
  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  index;
    logic [PIX_W-1:0]  pixel;
    logic [NUM_W-1:0]  num_x;
    logic [NUM_W-1:0]  num_y;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  // Saturated sizes that the back end needs.
  typedef struct packed {
    logic [SDIM_W-1:0] sw;
    logic [SDIM_W-1:0] sh;
    logic [FDIM_W-1:0] tw;
    logic [FDIM_W-1:0] th;
  } dims_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] frame_address;
    logic [COLOR_W-1:0] color_index;
  } result_t;

  function automatic logic [1:0] quant2(input logic [CHAN_W-1:0] c);
    logic [1:0] q;
    q = 2'd0;
    if (c >= CHAN_W'(QuantStep1)) q = 2'd1;
    if (c >= CHAN_W'(QuantStep2)) q = 2'd2;
    if (c >= CHAN_W'(QuantStep3)) q = 2'd3;
    return q;
  endfunction

endpackage

// ----- rtl/ssb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds no reset and no initial contents.
module ssb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ssb_div.sv -----
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// Stand-alone; the caller guarantees that the quotient fits in QUO_W bits.
module ssb_div #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 11,
  parameter int unsigned QUO_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int unsigned SH_W  = DEN_W + QUO_W - 1;
  localparam int unsigned REM_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int unsigned CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] den_q, den_d;
  logic [QUO_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             fits;

  assign fits = (rem_q >= den_q);

  // One trial subtraction per cycle against the shifted divisor.
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = REM_W'(num_i);
      den_d  = REM_W'(den_i) << (QUO_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUO_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - den_q;
      end
      quot_d = {quot_q[QUO_W-2:0], fits};
      den_d  = den_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/ssb_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, item classification, clipping,
// framebuffer address and scaling products, and the queue to the back end.
// Depends on ssb_pkg.
module ssb_front #(
  parameter int unsigned MAX_SOURCE_DIM = 256,
  parameter int unsigned MAX_FRAME_DIM  = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssb_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ssb_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: source_index, source_pixel, target_column, target_row, zero fill
  input  logic [ssb_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: opcode
  input  logic                             s_axis_tuser_i,
  output ssb_pkg::dims_t                   dims_o,
  output logic                             q_valid_o,
  output ssb_pkg::entry_t                  q_entry_o,
  input  logic                             q_pop_i
);

  localparam int unsigned PTR_W = (ssb_pkg::QUEUE_DEPTH > 1) ? $clog2(ssb_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ssb_pkg::QUEUE_DEPTH + 1);

  logic [ssb_pkg::SDIM_W-1:0] src_w_q, src_h_q;
  logic [ssb_pkg::FDIM_W-1:0] tgt_left_q, tgt_top_q, tgt_w_q, tgt_h_q, frm_w_q, frm_h_q;

  logic [ssb_pkg::SDIM_W-1:0] sw, sh;
  logic [ssb_pkg::FDIM_W-1:0] tw, th, fw, fh;

  logic [ssb_pkg::POS_W-1:0]    in_x, in_y;
  logic [ssb_pkg::FDIM_W:0]     fx, fy;
  logic [2*ssb_pkg::FDIM_W-1:0] addr_prod, addr_sum;
  logic                         zero_size, outside, clipped;
  ssb_pkg::entry_t              new_entry;

  ssb_pkg::entry_t  queue_q [ssb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  // Configuration writes; the source sizes keep their low nine bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= ssb_pkg::RST_SOURCE_WIDTH;
      src_h_q    <= ssb_pkg::RST_SOURCE_HEIGHT;
      tgt_left_q <= ssb_pkg::RST_TARGET_LEFT;
      tgt_top_q  <= ssb_pkg::RST_TARGET_TOP;
      tgt_w_q    <= ssb_pkg::RST_TARGET_WIDTH;
      tgt_h_q    <= ssb_pkg::RST_TARGET_HEIGHT;
      frm_w_q    <= ssb_pkg::RST_FRAME_WIDTH;
      frm_h_q    <= ssb_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssb_pkg::REG_SOURCE_WIDTH:  src_w_q    <= cfg_data_i[ssb_pkg::SDIM_W-1:0];
        ssb_pkg::REG_SOURCE_HEIGHT: src_h_q    <= cfg_data_i[ssb_pkg::SDIM_W-1:0];
        ssb_pkg::REG_TARGET_LEFT:   tgt_left_q <= cfg_data_i;
        ssb_pkg::REG_TARGET_TOP:    tgt_top_q  <= cfg_data_i;
        ssb_pkg::REG_TARGET_WIDTH:  tgt_w_q    <= cfg_data_i;
        ssb_pkg::REG_TARGET_HEIGHT: tgt_h_q    <= cfg_data_i;
        ssb_pkg::REG_FRAME_WIDTH:   frm_w_q    <= cfg_data_i;
        ssb_pkg::REG_FRAME_HEIGHT:  frm_h_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Oversized registers saturate to the configured bounds.
  assign sw = (32'(src_w_q) > MAX_SOURCE_DIM) ? ssb_pkg::SDIM_W'(MAX_SOURCE_DIM) : src_w_q;
  assign sh = (32'(src_h_q) > MAX_SOURCE_DIM) ? ssb_pkg::SDIM_W'(MAX_SOURCE_DIM) : src_h_q;
  assign tw = (32'(tgt_w_q) > MAX_FRAME_DIM) ? ssb_pkg::FDIM_W'(MAX_FRAME_DIM) : tgt_w_q;
  assign th = (32'(tgt_h_q) > MAX_FRAME_DIM) ? ssb_pkg::FDIM_W'(MAX_FRAME_DIM) : tgt_h_q;
  assign fw = (32'(frm_w_q) > MAX_FRAME_DIM) ? ssb_pkg::FDIM_W'(MAX_FRAME_DIM) : frm_w_q;
  assign fh = (32'(frm_h_q) > MAX_FRAME_DIM) ? ssb_pkg::FDIM_W'(MAX_FRAME_DIM) : frm_h_q;

  assign dims_o.sw = sw;
  assign dims_o.sh = sh;
  assign dims_o.tw = tw;
  assign dims_o.th = th;

  assign in_x = s_axis_tdata_i[ssb_pkg::IN_COL_LSB +: ssb_pkg::POS_W];
  assign in_y = s_axis_tdata_i[ssb_pkg::IN_ROW_LSB +: ssb_pkg::POS_W];

  // Rectangle test, framebuffer position and clipping.
  assign zero_size = (sw == '0) || (sh == '0) || (tw == '0) || (th == '0);
  assign outside   = ({1'b0, in_x} >= tw) || ({1'b0, in_y} >= th);
  assign fx = {tgt_left_q[ssb_pkg::FDIM_W-1], tgt_left_q} + {2'b00, in_x};
  assign fy = {tgt_top_q[ssb_pkg::FDIM_W-1], tgt_top_q} + {2'b00, in_y};
  assign clipped = fx[ssb_pkg::FDIM_W] || fy[ssb_pkg::FDIM_W]
                || (fx[ssb_pkg::FDIM_W-1:0] >= fw) || (fy[ssb_pkg::FDIM_W-1:0] >= fh);

  // Row-major framebuffer address, kept modulo the address width.
  assign addr_prod = {{ssb_pkg::FDIM_W{1'b0}}, fy[ssb_pkg::FDIM_W-1:0]}
                   * {{ssb_pkg::FDIM_W{1'b0}}, fw};
  assign addr_sum  = addr_prod + (2*ssb_pkg::FDIM_W)'(fx[ssb_pkg::FDIM_W-1:0]);

  // Build the queue entry; the scaling numerators are formed here and stored in the queue.
  always_comb begin
    new_entry.index = s_axis_tdata_i[ssb_pkg::IN_INDEX_LSB +: ssb_pkg::IDX_W];
    new_entry.pixel = s_axis_tdata_i[ssb_pkg::IN_PIXEL_LSB +: ssb_pkg::PIX_W];
    new_entry.num_x = {{ssb_pkg::SDIM_W{1'b0}}, in_x} * {{ssb_pkg::POS_W{1'b0}}, sw};
    new_entry.num_y = {{ssb_pkg::SDIM_W{1'b0}}, in_y} * {{ssb_pkg::POS_W{1'b0}}, sh};
    new_entry.addr  = addr_sum[ssb_pkg::ADDR_W-1:0];
    if (s_axis_tuser_i == ssb_pkg::OP_LOAD) begin
      new_entry.kind = ssb_pkg::KIND_LOAD;
    end else if (zero_size || outside || clipped) begin
      new_entry.kind = ssb_pkg::KIND_SKIP;
    end else begin
      new_entry.kind = ssb_pkg::KIND_DRAW;
    end
  end

  // Queue pointers and fill count.
  assign s_axis_tready_o = (count_q != CNT_W'(ssb_pkg::QUEUE_DEPTH));
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = q_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(ssb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(ssb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_entry;
    end
  end

  assign q_valid_o = (count_q != '0);
  assign q_entry_o = queue_q[rd_ptr_q];

endmodule

// ----- rtl/ssb_back.sv -----
`timescale 1ns / 1ps
// Back end: source bitmap store, the two scaling dividers, the source
// lookup, color quantization and the output register.
// Depends on ssb_pkg, ssb_ram and ssb_div.
module ssb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssb_pkg::dims_t                 dims_i,
  input  logic                           q_valid_i,
  input  ssb_pkg::entry_t                q_entry_i,
  output logic                           q_pop_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: frame_address, color_index, zero fill
  output logic [ssb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: write_valid
  output logic                           m_axis_tuser_o
);

  localparam int unsigned SADDR_W = 2 * ssb_pkg::SDIM_W;

  ssb_pkg::back_state_e state_q, state_d;
  ssb_pkg::entry_t      entry_q, entry_d;
  ssb_pkg::result_t     res_q, res_d;
  ssb_pkg::result_t     out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free, out_load;

  logic                       div_start, x_busy, y_busy;
  logic [ssb_pkg::SDIM_W-1:0] quot_x, quot_y, sx, sy;
  logic [SADDR_W-1:0]         src_prod, src_sum;

  logic                       ram_we, ram_re;
  logic [ssb_pkg::PIX_W-1:0]  ram_rdata;

  assign out_free = !out_valid_q || m_axis_tready_i;

  // Column and row scaling run side by side.
  ssb_div #(
    .NUM_W (ssb_pkg::NUM_W),
    .DEN_W (ssb_pkg::FDIM_W),
    .QUO_W (ssb_pkg::SDIM_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (q_entry_i.num_x),
    .den_i   (dims_i.tw),
    .busy_o  (x_busy),
    .quot_o  (quot_x)
  );

  ssb_div #(
    .NUM_W (ssb_pkg::NUM_W),
    .DEN_W (ssb_pkg::FDIM_W),
    .QUO_W (ssb_pkg::SDIM_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (q_entry_i.num_y),
    .den_i   (dims_i.th),
    .busy_o  (y_busy),
    .quot_o  (quot_y)
  );

  // Clamp to the last column and row, then form the linear source index.
  assign sx = (quot_x >= dims_i.sw) ? dims_i.sw - 1'b1 : quot_x;
  assign sy = (quot_y >= dims_i.sh) ? dims_i.sh - 1'b1 : quot_y;
  assign src_prod = {{ssb_pkg::SDIM_W{1'b0}}, sy} * {{ssb_pkg::SDIM_W{1'b0}}, dims_i.sw};
  assign src_sum  = src_prod + SADDR_W'(sx);

  ssb_ram #(
    .WIDTH (ssb_pkg::PIX_W),
    .DEPTH (ssb_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_q.index),
    .wdata_i (entry_q.pixel),
    .re_i    (ram_re),
    .raddr_i (src_sum[ssb_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssb_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.kind)
            ssb_pkg::KIND_LOAD: state_d = ssb_pkg::ST_WRITE;
            ssb_pkg::KIND_DRAW: state_d = ssb_pkg::ST_DIV;
            ssb_pkg::KIND_SKIP: state_d = ssb_pkg::ST_DONE;
            default:            state_d = ssb_pkg::ST_DONE;
          endcase
        end
      end
      ssb_pkg::ST_WRITE: state_d = ssb_pkg::ST_DONE;
      ssb_pkg::ST_DIV: begin
        if (!x_busy && !y_busy) begin
          state_d = ssb_pkg::ST_ADDR;
        end
      end
      ssb_pkg::ST_ADDR: state_d = ssb_pkg::ST_READ;
      ssb_pkg::ST_READ: state_d = ssb_pkg::ST_DONE;
      ssb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ssb_pkg::ST_IDLE;
        end
      end
      default: state_d = ssb_pkg::ST_IDLE;
    endcase
  end

  // State outputs: queue pop, divider start, store access, result build.
  always_comb begin
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    entry_d   = entry_q;
    res_d     = res_q;
    unique case (state_q)
      ssb_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          entry_d   = q_entry_i;
          res_d     = '0;
          div_start = (q_entry_i.kind == ssb_pkg::KIND_DRAW);
        end
      end
      ssb_pkg::ST_WRITE: ram_we = 1'b1;
      ssb_pkg::ST_DIV:   ;
      ssb_pkg::ST_ADDR:  ram_re = 1'b1;
      ssb_pkg::ST_READ: begin
        // An all-zero word is transparent and leaves the no-write result.
        if (ram_rdata != '0) begin
          res_d.write_valid   = 1'b1;
          res_d.frame_address = entry_q.addr;
          res_d.color_index   = {ssb_pkg::quant2(ram_rdata[23:16]),
                                 ssb_pkg::quant2(ram_rdata[15:8]),
                                 ssb_pkg::quant2(ram_rdata[7:0])};
        end
      end
      ssb_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // Output register: loaded when free or being drained in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.write_valid;
  assign m_axis_tdata_o  = ssb_pkg::OUT_DATA_W'({out_q.color_index, out_q.frame_address});

  // Both dividers start together and must finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) x_busy == y_busy)
    else $error("scaling dividers out of step");

  // A finished item moves into a free output register and the FSM returns idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssb_pkg::ST_DONE && out_free) |=> (out_valid_q && state_q == ssb_pkg::ST_IDLE))
    else $error("finished result not transferred to output register");

  // Store read data is only used in the cycle after its address was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ssb_pkg::ST_READ |-> $past(state_q) == ssb_pkg::ST_ADDR)
    else $error("store read data used without a read");

  // Only load items write the source store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> entry_q.kind == ssb_pkg::KIND_LOAD)
    else $error("store written by a non-load item");

endmodule

// ----- rtl/scaled_sprite_blit_palette_top.sv -----
`timescale 1ns / 1ps
// Loads pass the back end's idle, write and done states; skipped draws pass
// idle and done; drawn pixels pass idle, divide, address, read and done. The
// back end holds one item at a time, and a draw is set by the two bit-serial
// dividers (one quotient bit each) plus the registered store read.
// The front queue takes two items while the back end works or the output stalls.
// Reset (async, active low) restores register defaults; the store is not cleared.
module scaled_sprite_blit_palette_top #(
  parameter int unsigned MAX_SOURCE_DIM = 256,
  parameter int unsigned MAX_FRAME_DIM  = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssb_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssb_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: source_index, source_pixel, target_column, target_row, zero fill
  input  logic [ssb_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: opcode
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: frame_address, color_index, zero fill
  output logic [ssb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: write_valid
  output logic                           m_axis_tuser_o
);

  ssb_pkg::dims_t  dims;
  ssb_pkg::entry_t q_entry;
  logic            q_valid, q_pop;

  // Accept, classify and queue items.
  ssb_front #(
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .MAX_FRAME_DIM  (MAX_FRAME_DIM)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .dims_o          (dims),
    .q_valid_o       (q_valid),
    .q_entry_o       (q_entry),
    .q_pop_i         (q_pop)
  );

  // Execute loads and draws in order.
  ssb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dims_i          (dims),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
